/* rtl/core/route_relocate_move_evaluator_top_assert.svh */
// Assertion macros used by the relocate move evaluator RTL.
// Depends on nothing; included by rrme_ctrl, which checks its own control.
`ifndef ROUTE_RELOCATE_MOVE_EVALUATOR_TOP_ASSERT_SVH
`define ROUTE_RELOCATE_MOVE_EVALUATOR_TOP_ASSERT_SVH

// same-cycle implication
`define RRME_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RRME_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/rrme_pkg.sv */
// Shared types, codes and defaults of the relocate move evaluator.
// Depends on nothing; used by every module of the block but rrme_ram.
package rrme_pkg;

   localparam int DEF_MAX_VERTICES  = 64;
   localparam int DEF_MAX_ROUTES    = 8;
   localparam int DEF_MAX_ROUTE_LEN = 64;
   localparam int DEF_DIST_BITS     = 16;

   localparam int CMD_W     = 3;
   localparam int LINE_W    = 3;
   localparam int TAKE_W    = 6;
   localparam int INSERT_W  = 7;
   localparam int VERTEX_W  = 6;
   localparam int VALUE_W   = 22;
   localparam int STATUS_W  = 2;
   localparam int DELTA_W   = 19;
   localparam int PENALTY_W = 41;
   localparam int WEIGHT_W  = 16;
   localparam int ROUTES_W  = 4;
   localparam int CSR_IDX_W = 2;
   localparam int TOTAL_W   = 22;

   localparam int ENTRY_LAST = 5;
   localparam int DIST_LAST  = 6;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_DIST   = 3'd0,
      CMD_LOAD_ENTRY  = 3'd1,
      CMD_SET_LENGTH  = 3'd2,
      CMD_SET_REQ     = 3'd3,
      CMD_SET_TOTAL   = 3'd4,
      CMD_EVALUATE    = 3'd5,
      CMD_APPLY       = 3'd6,
      CMD_NOP         = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE     = 2'd0,
      ST_REQUIRED = 2'd1,
      ST_INVALID  = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DIST_WEIGHT   = 2'd0,
      REG_SPREAD_WEIGHT = 2'd1,
      REG_MAX_WEIGHT    = 2'd2,
      REG_ROUTES        = 2'd3
   } reg_index_type;

   typedef enum logic [4:0] {
      STEP_IDLE,
      STEP_CAPTURE,
      STEP_LOAD,
      STEP_LEN1,
      STEP_LEN2,
      STEP_ENTRY,
      STEP_DIST,
      STEP_TOTAL,
      STEP_SCAN,
      STEP_MULT,
      STEP_SUM,
      STEP_SH1_RD,
      STEP_SH1_WR,
      STEP_SH2_RD,
      STEP_SH2_WR,
      STEP_SET_INVALID,
      STEP_SET_REQ
   } step_type;

   typedef struct packed {
      step_type step;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_load;
      logic is_move;
      logic is_apply;
      logic bad_move;
      logic req_hit;
      logic sh1_done;
      logic sh2_done;
      logic scan_last;
   } dp_status_type;

endpackage

/* rtl/core/route_relocate_move_evaluator_top.sv */
// Top level of the relocate move evaluator: control registers, sequencer and datapath.
// Depends on rrme_pkg, rrme_ctrl, rrme_dp and rrme_ram.
//
//   port group | direction | handshake
//   req_*      | in        | taken when start is high and busy is low
//   rsp_*      | out       | valid for one cycle while rsp_strobe is high
//   csr_*      | in        | written when csr_write_enable is high
//
// Loads and no-ops end after decode, rejected moves after the route check, and skipped
// moves (required vertex) after the entry reads. Evaluate reads five entries and six
// distances through simple dual-port RAMs, and the totals scan takes one route a cycle.
// Apply then shifts the entries of both routes, reading and then writing each one.
// Reset clears lengths, totals and required flags and restores default weights.
// The result cannot be held off; busy stays high until it is shown.
module route_relocate_move_evaluator_top #(
   parameter int MAX_VERTICES  = rrme_pkg::DEF_MAX_VERTICES,
   parameter int MAX_ROUTES    = rrme_pkg::DEF_MAX_ROUTES,
   parameter int MAX_ROUTE_LEN = rrme_pkg::DEF_MAX_ROUTE_LEN,
   parameter int DIST_BITS     = rrme_pkg::DEF_DIST_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [rrme_pkg::CMD_W-1:0]            req_cmd,
   input  logic [rrme_pkg::LINE_W-1:0]           req_first_line,
   input  logic [rrme_pkg::LINE_W-1:0]           req_second_line,
   input  logic [rrme_pkg::TAKE_W-1:0]           req_take_position,
   input  logic [rrme_pkg::INSERT_W-1:0]         req_insert_position,
   input  logic [rrme_pkg::VERTEX_W-1:0]         req_from_vertex,
   input  logic [rrme_pkg::VERTEX_W-1:0]         req_to_vertex,
   input  logic [rrme_pkg::VALUE_W-1:0]          req_load_value,
   output logic                                  rsp_strobe,
   output logic [rrme_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [rrme_pkg::DELTA_W-1:0]   rsp_first_delta,
   output logic signed [rrme_pkg::DELTA_W-1:0]   rsp_second_delta,
   output logic signed [rrme_pkg::PENALTY_W-1:0] rsp_penalty_delta,
   input  logic                                  csr_write_enable,
   input  logic [rrme_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rrme_pkg::WEIGHT_W-1:0]         csr_data
);

   localparam int CNT_W = ($clog2(MAX_ROUTES) > 3) ? $clog2(MAX_ROUTES) : 3;
   localparam int NW    = $clog2(MAX_ROUTES + 1);

   logic [rrme_pkg::WEIGHT_W-1:0] dist_weight_ff, spread_weight_ff, max_weight_ff;
   logic [rrme_pkg::ROUTES_W-1:0] routes_ff;
   logic [NW-1:0]                 n_routes;
   rrme_pkg::ctl_cmd_type         ctl_cmd;
   rrme_pkg::dp_status_type       dp_status;
   logic [CNT_W-1:0]              cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_weight_ff   <= rrme_pkg::WEIGHT_W'(256);
         spread_weight_ff <= rrme_pkg::WEIGHT_W'(256);
         max_weight_ff    <= rrme_pkg::WEIGHT_W'(256);
         routes_ff        <= rrme_pkg::ROUTES_W'(2);
      end else if (csr_write_enable) begin
         unique case (rrme_pkg::reg_index_type'(csr_index))
            rrme_pkg::REG_DIST_WEIGHT:   dist_weight_ff   <= csr_data;
            rrme_pkg::REG_SPREAD_WEIGHT: spread_weight_ff <= csr_data;
            rrme_pkg::REG_MAX_WEIGHT:    max_weight_ff    <= csr_data;
            rrme_pkg::REG_ROUTES:        routes_ff <= rrme_pkg::ROUTES_W'(csr_data);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      priority if (int'(routes_ff) < 2) n_routes = NW'(2);
      else if (int'(routes_ff) > MAX_ROUTES) n_routes = NW'(MAX_ROUTES);
      else n_routes = NW'(routes_ff);
   end

   rrme_ctrl #(.CNT_W(CNT_W)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .status     (dp_status),
      .cmd        (ctl_cmd),
      .cnt        (cnt),
      .rsp_strobe (rsp_strobe)
   );

   rrme_dp #(
      .MAX_VERTICES  (MAX_VERTICES),
      .MAX_ROUTES    (MAX_ROUTES),
      .MAX_ROUTE_LEN (MAX_ROUTE_LEN),
      .DIST_BITS     (DIST_BITS),
      .CNT_W         (CNT_W),
      .NW            (NW)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (ctl_cmd),
      .cnt                 (cnt),
      .status              (dp_status),
      .n_routes            (n_routes),
      .dist_weight         (dist_weight_ff),
      .spread_weight       (spread_weight_ff),
      .max_weight          (max_weight_ff),
      .req_cmd             (req_cmd),
      .req_first_line      (req_first_line),
      .req_second_line     (req_second_line),
      .req_take_position   (req_take_position),
      .req_insert_position (req_insert_position),
      .req_from_vertex     (req_from_vertex),
      .req_to_vertex       (req_to_vertex),
      .req_load_value      (req_load_value),
      .rsp_status          (rsp_status),
      .rsp_first_delta     (rsp_first_delta),
      .rsp_second_delta    (rsp_second_delta),
      .rsp_penalty_delta   (rsp_penalty_delta)
   );

endmodule

/* rtl/core/rrme_ram.sv */
// Generic simple dual-port RAM with registered read.
// Depends on nothing.
module rrme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/rrme_ctrl.sv */
// Sequencer of the relocate move evaluator: steps the datapath per request.
// Depends on rrme_pkg and the assertion macro header.
`include "route_relocate_move_evaluator_top_assert.svh"

module rrme_ctrl #(
   parameter int CNT_W = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rrme_pkg::dp_status_type status,
   output rrme_pkg::ctl_cmd_type  cmd,
   output logic [CNT_W-1:0]       cnt,
   output logic                   rsp_strobe
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_LEN1, S_LEN2, S_CHECK, S_ENTRY, S_REQ, S_DIST,
      S_TOTAL, S_SCAN, S_MULT, S_SUM, S_SH1_RD, S_SH1_WR, S_SH2_RD, S_SH2_WR
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             rsp_strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               if (status.is_move) begin
                  state_ff <= S_LEN1;
               end else begin
                  state_ff      <= S_IDLE;
                  rsp_strobe_ff <= 1'b1;
               end
            end
            S_LEN1: state_ff <= S_LEN2;
            S_LEN2: state_ff <= S_CHECK;
            S_CHECK: begin
               cnt_ff <= '0;
               if (status.bad_move) begin
                  state_ff      <= S_IDLE;
                  rsp_strobe_ff <= 1'b1;
               end else begin
                  state_ff <= S_ENTRY;
               end
            end
            S_ENTRY: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(rrme_pkg::ENTRY_LAST)) begin
                  state_ff <= S_REQ;
               end
            end
            S_REQ: begin
               cnt_ff <= '0;
               if (status.req_hit) begin
                  state_ff      <= S_IDLE;
                  rsp_strobe_ff <= 1'b1;
               end else begin
                  state_ff <= S_DIST;
               end
            end
            S_DIST: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(rrme_pkg::DIST_LAST)) begin
                  state_ff <= S_TOTAL;
               end
            end
            S_TOTAL: begin
               cnt_ff   <= '0;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (status.scan_last) begin
                  state_ff <= S_MULT;
               end
            end
            S_MULT: state_ff <= S_SUM;
            S_SUM: begin
               if (status.is_apply) begin
                  state_ff <= S_SH1_RD;
               end else begin
                  state_ff      <= S_IDLE;
                  rsp_strobe_ff <= 1'b1;
               end
            end
            S_SH1_RD: state_ff <= status.sh1_done ? S_SH2_RD : S_SH1_WR;
            S_SH1_WR: state_ff <= S_SH1_RD;
            S_SH2_RD: begin
               if (status.sh2_done) begin
                  state_ff      <= S_IDLE;
                  rsp_strobe_ff <= 1'b1;
               end else begin
                  state_ff <= S_SH2_WR;
               end
            end
            S_SH2_WR: state_ff <= S_SH2_RD;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd.step = rrme_pkg::STEP_IDLE;
      unique case (state_ff)
         S_IDLE:   cmd.step = start ? rrme_pkg::STEP_CAPTURE : rrme_pkg::STEP_IDLE;
         S_DECODE: cmd.step = rrme_pkg::STEP_LOAD;
         S_LEN1:   cmd.step = rrme_pkg::STEP_LEN1;
         S_LEN2:   cmd.step = rrme_pkg::STEP_LEN2;
         S_CHECK:  cmd.step = status.bad_move ? rrme_pkg::STEP_SET_INVALID
                                              : rrme_pkg::STEP_IDLE;
         S_ENTRY:  cmd.step = rrme_pkg::STEP_ENTRY;
         S_REQ:    cmd.step = status.req_hit ? rrme_pkg::STEP_SET_REQ
                                             : rrme_pkg::STEP_IDLE;
         S_DIST:   cmd.step = rrme_pkg::STEP_DIST;
         S_TOTAL:  cmd.step = rrme_pkg::STEP_TOTAL;
         S_SCAN:   cmd.step = rrme_pkg::STEP_SCAN;
         S_MULT:   cmd.step = rrme_pkg::STEP_MULT;
         S_SUM:    cmd.step = rrme_pkg::STEP_SUM;
         S_SH1_RD: cmd.step = rrme_pkg::STEP_SH1_RD;
         S_SH1_WR: cmd.step = rrme_pkg::STEP_SH1_WR;
         S_SH2_RD: cmd.step = rrme_pkg::STEP_SH2_RD;
         S_SH2_WR: cmd.step = rrme_pkg::STEP_SH2_WR;
         default:  cmd.step = rrme_pkg::STEP_IDLE;
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign cnt        = cnt_ff;
   assign rsp_strobe = rsp_strobe_ff;

   `RRME_ASSERT_IMP(a_strobe_idle, clock, reset, rsp_strobe_ff, state_ff == S_IDLE, "strobe while busy")
   `RRME_ASSERT_NXT(a_accept_busy, clock, reset, start && state_ff == S_IDLE, state_ff != S_IDLE, "request not taken")
   `RRME_ASSERT_NXT(a_single_strobe, clock, reset, rsp_strobe_ff, !rsp_strobe_ff, "strobe held twice")
   `RRME_ASSERT_IMP(a_end_strobe, clock, reset, $fell(state_ff != S_IDLE), rsp_strobe_ff, "request ended without result")

endmodule

/* rtl/core/rrme_dp.sv */
// Datapath of the relocate move evaluator: route stores, distance lookups,
// scans and penalty arithmetic. Depends on rrme_pkg and rrme_ram.
module rrme_dp #(
   parameter int MAX_VERTICES  = rrme_pkg::DEF_MAX_VERTICES,
   parameter int MAX_ROUTES    = rrme_pkg::DEF_MAX_ROUTES,
   parameter int MAX_ROUTE_LEN = rrme_pkg::DEF_MAX_ROUTE_LEN,
   parameter int DIST_BITS     = rrme_pkg::DEF_DIST_BITS,
   parameter int CNT_W         = 3,
   parameter int NW            = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rrme_pkg::ctl_cmd_type                 cmd,
   input  logic [CNT_W-1:0]                      cnt,
   output rrme_pkg::dp_status_type               status,
   input  logic [NW-1:0]                         n_routes,
   input  logic [rrme_pkg::WEIGHT_W-1:0]         dist_weight,
   input  logic [rrme_pkg::WEIGHT_W-1:0]         spread_weight,
   input  logic [rrme_pkg::WEIGHT_W-1:0]         max_weight,
   input  logic [rrme_pkg::CMD_W-1:0]            req_cmd,
   input  logic [rrme_pkg::LINE_W-1:0]           req_first_line,
   input  logic [rrme_pkg::LINE_W-1:0]           req_second_line,
   input  logic [rrme_pkg::TAKE_W-1:0]           req_take_position,
   input  logic [rrme_pkg::INSERT_W-1:0]         req_insert_position,
   input  logic [rrme_pkg::VERTEX_W-1:0]         req_from_vertex,
   input  logic [rrme_pkg::VERTEX_W-1:0]         req_to_vertex,
   input  logic [rrme_pkg::VALUE_W-1:0]          req_load_value,
   output logic [rrme_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [rrme_pkg::DELTA_W-1:0]   rsp_first_delta,
   output logic signed [rrme_pkg::DELTA_W-1:0]   rsp_second_delta,
   output logic signed [rrme_pkg::PENALTY_W-1:0] rsp_penalty_delta
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int RW  = $clog2(MAX_ROUTES);
   localparam int LW  = $clog2(MAX_ROUTE_LEN + 1);
   localparam int EAW = $clog2(MAX_ROUTES * MAX_ROUTE_LEN);
   localparam int DAW = $clog2(MAX_VERTICES * MAX_VERTICES);
   localparam int AW  = DIST_BITS + 3;
   localparam int TW  = rrme_pkg::TOTAL_W;
   localparam int SW  = ((AW > TW) ? AW : TW) + 2;
   localparam int XW  = rrme_pkg::VERTEX_W;
   localparam int WW  = rrme_pkg::WEIGHT_W;
   localparam int PDW = AW + 1 + WW + 1;
   localparam int PSW = TW + 2 + WW + 1;
   localparam int PMW = TW + 1 + WW + 1;
   localparam int PW  = rrme_pkg::PENALTY_W;

   function automatic logic [EAW-1:0] eaddr(input int r, input int p);
      return EAW'(r * MAX_ROUTE_LEN + p);
   endfunction

   function automatic logic [DAW-1:0] daddr(input int a, input int b);
      return DAW'(a * MAX_VERTICES + b);
   endfunction

   // request registers
   rrme_pkg::cmd_type            cmd_ff;
   logic [rrme_pkg::LINE_W-1:0]  l1_ff, l2_ff;
   logic [rrme_pkg::TAKE_W-1:0]  p1_ff;
   logic [rrme_pkg::INSERT_W-1:0] p2_ff;
   logic [XW-1:0]                fv_ff, tv_ff;
   logic [rrme_pkg::VALUE_W-1:0] val_ff;

   // route state
   logic [LW-1:0]         len_ff [MAX_ROUTES];
   logic [TW-1:0]         tot_ff [MAX_ROUTES];
   logic [MAX_VERTICES-1:0] req_flag_ff;

   // working registers
   logic [LW-1:0]          len1_ff, len2_ff;
   logic [TW-1:0]          tot1_ff, tot2_ff, t1_ff, t2_ff;
   logic [XW-1:0]          v_ff, ea_ff, eb_ff, ec_ff, ee_ff;
   logic signed [AW-1:0]   d1_ff, d2_ff;
   logic [TW-1:0]          mn1_ff, mx1_ff, mn2_ff, mx2_ff;
   logic signed [PDW-1:0]  pd_ff;
   logic signed [PSW-1:0]  ps_ff;
   logic signed [PMW-1:0]  pm_ff;
   logic [LW-1:0]          pos_ff;
   rrme_pkg::status_type   status_ff;
   logic signed [PW-1:0]   pen_ff;

   // memory ports
   logic                 dram_we, eram_we;
   logic [DAW-1:0]       dram_wa, dram_ra;
   logic [DIST_BITS-1:0] dram_rd;
   logic [EAW-1:0]       eram_wa, eram_ra;
   logic [XW-1:0]        eram_wd, eram_rd;

   logic [RW-1:0]        tsel;
   logic [LW-1:0]        len_rd;
   logic [TW-1:0]        tot_rd;
   logic [TW-1:0]        scan_b;
   logic [AW-1:0]        dist_ext;
   logic signed [SW-1:0] t1_sum, t2_sum, tmax_s;
   logic [TW-1:0]        t1_cl, t2_cl;
   logic signed [AW:0]   dsum;
   logic signed [TW+1:0] sdiff;
   logic signed [TW:0]   mdiff;
   logic [LW-1:0]        len_load;
   logic                 p1nz, p1last, p2nz, p2end;
   logic                 ld_dist_ok, ld_entry_ok, ld_route_ok, ld_vertex_ok;

   rrme_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_VERTICES * MAX_VERTICES)) u_dist_ram (
      .clock   (clock),
      .wr_en   (dram_we),
      .wr_addr (dram_wa),
      .wr_data (DIST_BITS'(val_ff)),
      .rd_addr (dram_ra),
      .rd_data (dram_rd)
   );

   rrme_ram #(.WIDTH(XW), .DEPTH(MAX_ROUTES * MAX_ROUTE_LEN)) u_entry_ram (
      .clock   (clock),
      .wr_en   (eram_we),
      .wr_addr (eram_wa),
      .wr_data (eram_wd),
      .rd_addr (eram_ra),
      .rd_data (eram_rd)
   );

   assign ld_dist_ok   = (int'(fv_ff) < MAX_VERTICES) && (int'(tv_ff) < MAX_VERTICES);
   assign ld_route_ok  = (int'(l1_ff) < MAX_ROUTES);
   assign ld_vertex_ok = (int'(fv_ff) < MAX_VERTICES);
   assign ld_entry_ok  = ld_route_ok && ld_vertex_ok && (int'(p1_ff) < MAX_ROUTE_LEN);
   assign len_load     = (int'(val_ff) > MAX_ROUTE_LEN) ? LW'(MAX_ROUTE_LEN) : LW'(val_ff);

   assign p1nz   = (p1_ff != '0);
   assign p1last = (int'(p1_ff) + 1 == int'(len1_ff));
   assign p2nz   = (p2_ff != '0);
   assign p2end  = (int'(p2_ff) == int'(len2_ff));

   always_comb begin
      priority case (cmd.step)
         rrme_pkg::STEP_LEN1: tsel = RW'(l1_ff);
         rrme_pkg::STEP_LEN2: tsel = RW'(l2_ff);
         default:             tsel = RW'(cnt);
      endcase
   end

   assign len_rd   = len_ff[tsel];
   assign tot_rd   = tot_ff[tsel];
   assign dist_ext = AW'(dram_rd);

   always_comb begin
      if (int'(cnt) == int'(l1_ff)) begin
         scan_b = t1_ff;
      end else if (int'(cnt) == int'(l2_ff)) begin
         scan_b = t2_ff;
      end else begin
         scan_b = tot_rd;
      end
   end

   assign tmax_s = $signed({{(SW-TW){1'b0}}, {TW{1'b1}}});
   assign t1_sum = $signed({{(SW-TW){1'b0}}, tot1_ff}) + SW'(d1_ff);
   assign t2_sum = $signed({{(SW-TW){1'b0}}, tot2_ff}) + SW'(d2_ff);

   always_comb begin
      priority if (t1_sum < 0) t1_cl = '0;
      else if (t1_sum > tmax_s) t1_cl = '1;
      else t1_cl = TW'(t1_sum);
      priority if (t2_sum < 0) t2_cl = '0;
      else if (t2_sum > tmax_s) t2_cl = '1;
      else t2_cl = TW'(t2_sum);
   end

   assign dsum  = (AW+1)'(d1_ff) + (AW+1)'(d2_ff);
   assign sdiff = ($signed({2'b00, mx2_ff}) - $signed({2'b00, mn2_ff}))
                - ($signed({2'b00, mx1_ff}) - $signed({2'b00, mn1_ff}));
   assign mdiff = $signed({1'b0, mx2_ff}) - $signed({1'b0, mx1_ff});

   // memory addressing
   always_comb begin
      dram_we = 1'b0;
      dram_wa = daddr(int'(fv_ff), int'(tv_ff));
      dram_ra = '0;
      eram_we = 1'b0;
      eram_wa = eaddr(int'(l1_ff), int'(p1_ff));
      eram_wd = fv_ff;
      eram_ra = '0;
      unique case (cmd.step)
         rrme_pkg::STEP_LOAD: begin
            dram_we = (cmd_ff == rrme_pkg::CMD_LOAD_DIST) && ld_dist_ok;
            eram_we = (cmd_ff == rrme_pkg::CMD_LOAD_ENTRY) && ld_entry_ok;
         end
         rrme_pkg::STEP_ENTRY: begin
            unique case (int'(cnt))
               0:       eram_ra = eaddr(int'(l1_ff), int'(p1_ff));
               1:       eram_ra = eaddr(int'(l1_ff), int'(p1_ff) - 1);
               2:       eram_ra = eaddr(int'(l1_ff), int'(p1_ff) + 1);
               3:       eram_ra = eaddr(int'(l2_ff), int'(p2_ff) - 1);
               default: eram_ra = eaddr(int'(l2_ff), int'(p2_ff));
            endcase
         end
         rrme_pkg::STEP_DIST: begin
            unique case (int'(cnt))
               0:       dram_ra = daddr(int'(ea_ff), int'(v_ff));
               1:       dram_ra = daddr(int'(v_ff), int'(eb_ff));
               2:       dram_ra = daddr(int'(ea_ff), int'(eb_ff));
               3:       dram_ra = daddr(int'(ec_ff), int'(v_ff));
               4:       dram_ra = daddr(int'(v_ff), int'(ee_ff));
               default: dram_ra = daddr(int'(ec_ff), int'(ee_ff));
            endcase
         end
         rrme_pkg::STEP_SH1_RD: eram_ra = eaddr(int'(l1_ff), int'(pos_ff) + 1);
         rrme_pkg::STEP_SH1_WR: begin
            eram_we = 1'b1;
            eram_wa = eaddr(int'(l1_ff), int'(pos_ff));
            eram_wd = eram_rd;
         end
         rrme_pkg::STEP_SH2_RD: begin
            eram_ra = eaddr(int'(l2_ff), int'(pos_ff) - 1);
            eram_we = status.sh2_done;
            eram_wa = eaddr(int'(l2_ff), int'(p2_ff));
            eram_wd = v_ff;
         end
         rrme_pkg::STEP_SH2_WR: begin
            eram_we = 1'b1;
            eram_wa = eaddr(int'(l2_ff), int'(pos_ff));
            eram_wd = eram_rd;
         end
         default: begin
         end
      endcase
   end

   // route state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ROUTES; i++) begin
            len_ff[i] <= '0;
            tot_ff[i] <= '0;
         end
         req_flag_ff <= '0;
      end else begin
         unique case (cmd.step)
            rrme_pkg::STEP_LOAD: begin
               if (cmd_ff == rrme_pkg::CMD_SET_LENGTH && ld_route_ok) begin
                  len_ff[RW'(l1_ff)] <= len_load;
               end
               if (cmd_ff == rrme_pkg::CMD_SET_TOTAL && ld_route_ok) begin
                  tot_ff[RW'(l1_ff)] <= TW'(val_ff);
               end
               if (cmd_ff == rrme_pkg::CMD_SET_REQ && ld_vertex_ok) begin
                  req_flag_ff[VW'(fv_ff)] <= val_ff[0];
               end
            end
            rrme_pkg::STEP_SUM: begin
               if (cmd_ff == rrme_pkg::CMD_APPLY) begin
                  tot_ff[RW'(l1_ff)] <= t1_ff;
                  tot_ff[RW'(l2_ff)] <= t2_ff;
               end
            end
            rrme_pkg::STEP_SH1_RD: begin
               if (status.sh1_done) begin
                  len_ff[RW'(l1_ff)] <= len1_ff - 1'b1;
               end
            end
            rrme_pkg::STEP_SH2_RD: begin
               if (status.sh2_done) begin
                  len_ff[RW'(l2_ff)] <= len2_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      unique case (cmd.step)
         rrme_pkg::STEP_CAPTURE: begin
            cmd_ff    <= rrme_pkg::cmd_type'(req_cmd);
            l1_ff     <= req_first_line;
            l2_ff     <= req_second_line;
            p1_ff     <= req_take_position;
            p2_ff     <= req_insert_position;
            fv_ff     <= req_from_vertex;
            tv_ff     <= req_to_vertex;
            val_ff    <= req_load_value;
            status_ff <= rrme_pkg::ST_DONE;
            d1_ff     <= '0;
            d2_ff     <= '0;
            pen_ff    <= '0;
         end
         rrme_pkg::STEP_LEN1: begin
            len1_ff <= len_rd;
            tot1_ff <= tot_rd;
         end
         rrme_pkg::STEP_LEN2: begin
            len2_ff <= len_rd;
            tot2_ff <= tot_rd;
         end
         rrme_pkg::STEP_SET_INVALID: status_ff <= rrme_pkg::ST_INVALID;
         rrme_pkg::STEP_SET_REQ:     status_ff <= rrme_pkg::ST_REQUIRED;
         rrme_pkg::STEP_ENTRY: begin
            unique case (int'(cnt))
               1: v_ff  <= eram_rd;
               2: ea_ff <= eram_rd;
               3: eb_ff <= eram_rd;
               4: ec_ff <= eram_rd;
               5: ee_ff <= eram_rd;
               default: begin
               end
            endcase
         end
         rrme_pkg::STEP_DIST: begin
            unique case (int'(cnt))
               1: if (p1nz) d1_ff <= d1_ff - $signed(dist_ext);
               2: if (!p1last) d1_ff <= d1_ff - $signed(dist_ext);
               3: if (p1nz && !p1last) d1_ff <= d1_ff + $signed(dist_ext);
               4: if (p2nz) d2_ff <= d2_ff + $signed(dist_ext);
               5: if (!p2end) d2_ff <= d2_ff + $signed(dist_ext);
               6: if (p2nz && !p2end) d2_ff <= d2_ff - $signed(dist_ext);
               default: begin
               end
            endcase
         end
         rrme_pkg::STEP_TOTAL: begin
            t1_ff <= t1_cl;
            t2_ff <= t2_cl;
         end
         rrme_pkg::STEP_SCAN: begin
            if (cnt == '0) begin
               mn1_ff <= tot_rd;
               mx1_ff <= tot_rd;
               mn2_ff <= scan_b;
               mx2_ff <= scan_b;
            end else begin
               if (tot_rd < mn1_ff) mn1_ff <= tot_rd;
               if (tot_rd > mx1_ff) mx1_ff <= tot_rd;
               if (scan_b < mn2_ff) mn2_ff <= scan_b;
               if (scan_b > mx2_ff) mx2_ff <= scan_b;
            end
         end
         rrme_pkg::STEP_MULT: begin
            pd_ff <= dsum * $signed({1'b0, dist_weight});
            ps_ff <= sdiff * $signed({1'b0, spread_weight});
            pm_ff <= mdiff * $signed({1'b0, max_weight});
         end
         rrme_pkg::STEP_SUM: begin
            pen_ff <= PW'(pd_ff) + PW'(ps_ff) + PW'(pm_ff);
            pos_ff <= LW'(p1_ff);
         end
         rrme_pkg::STEP_SH1_RD: begin
            if (status.sh1_done) pos_ff <= len2_ff;
         end
         rrme_pkg::STEP_SH1_WR: pos_ff <= pos_ff + 1'b1;
         rrme_pkg::STEP_SH2_WR: pos_ff <= pos_ff - 1'b1;
         default: begin
         end
      endcase
   end

   assign status.is_load  = (cmd_ff == rrme_pkg::CMD_LOAD_DIST)
                         || (cmd_ff == rrme_pkg::CMD_LOAD_ENTRY)
                         || (cmd_ff == rrme_pkg::CMD_SET_LENGTH)
                         || (cmd_ff == rrme_pkg::CMD_SET_REQ)
                         || (cmd_ff == rrme_pkg::CMD_SET_TOTAL);
   assign status.is_move  = (cmd_ff == rrme_pkg::CMD_EVALUATE)
                         || (cmd_ff == rrme_pkg::CMD_APPLY);
   assign status.is_apply = (cmd_ff == rrme_pkg::CMD_APPLY);
   assign status.bad_move = (int'(l1_ff) >= int'(n_routes))
                         || (int'(l2_ff) >= int'(n_routes))
                         || (l1_ff == l2_ff)
                         || (int'(p1_ff) >= int'(len1_ff))
                         || (int'(p2_ff) > int'(len2_ff))
                         || (int'(len2_ff) >= MAX_ROUTE_LEN);
   assign status.req_hit  = (int'(v_ff) < MAX_VERTICES) && req_flag_ff[VW'(v_ff)];
   assign status.sh1_done = (int'(pos_ff) + 1 >= int'(len1_ff));
   assign status.sh2_done = (pos_ff == LW'(p2_ff));
   assign status.scan_last = (int'(cnt) + 1 >= int'(n_routes));

   assign rsp_status        = status_ff;
   assign rsp_first_delta   = rrme_pkg::DELTA_W'(d1_ff);
   assign rsp_second_delta  = rrme_pkg::DELTA_W'(d2_ff);
   assign rsp_penalty_delta = pen_ff;

endmodule

/* dv/tb_route_relocate_move_evaluator_top.sv */
// Testbench for the relocate move evaluator: loads routes, distances and totals, then
// checks the result of every request against a behavioral model kept in this file.
// Depends on rrme_pkg and route_relocate_move_evaluator_top.
module tb_route_relocate_move_evaluator_top;
   import rrme_pkg::*;

   localparam int IDLE_LIMIT = 4000;

   typedef struct {
      logic [STATUS_W-1:0]         status;
      logic signed [DELTA_W-1:0]   first_delta;
      logic signed [DELTA_W-1:0]   second_delta;
      logic signed [PENALTY_W-1:0] penalty_delta;
   } move_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [CMD_W-1:0]            req_cmd = '0;
   logic [LINE_W-1:0]           req_first_line = '0;
   logic [LINE_W-1:0]           req_second_line = '0;
   logic [TAKE_W-1:0]           req_take_position = '0;
   logic [INSERT_W-1:0]         req_insert_position = '0;
   logic [VERTEX_W-1:0]         req_from_vertex = '0;
   logic [VERTEX_W-1:0]         req_to_vertex = '0;
   logic [VALUE_W-1:0]          req_load_value = '0;
   logic                        rsp_strobe;
   logic [STATUS_W-1:0]         rsp_status;
   logic signed [DELTA_W-1:0]   rsp_first_delta;
   logic signed [DELTA_W-1:0]   rsp_second_delta;
   logic signed [PENALTY_W-1:0] rsp_penalty_delta;
   logic                        csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [WEIGHT_W-1:0]         csr_data = '0;

   route_relocate_move_evaluator_top dut (.*);

   // model state
   logic [15:0]         dist_mem [64][64];
   logic [VERTEX_W-1:0] route_vtx [8][64];
   int                  route_len [8];
   longint              route_tot [8];
   bit                  req_flag [64];
   longint              dist_w, spread_w, max_w;
   int                  routes_raw;
   // route entries only ever hold vertices of this set, whose distances are all loaded
   int                  vset [8] = '{0, 1, 2, 3, 60, 61, 62, 63};

   move_result_type pending_results [$];
   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  no_gaps = 1'b0;

   initial forever #5 clock = ~clock;

   function automatic int active_routes();
      if (routes_raw < 2) return 2;
      if (routes_raw > 8) return 8;
      return routes_raw;
   endfunction

   function automatic longint clamp_total(longint t);
      if (t < 0) return 0;
      if (t > 4194303) return 4194303;
      return t;
   endfunction

   function automatic move_result_type relocate_outcome(cmd_type c, int l1, int l2, int p1,
                                                       int p2, int fv, int tv, int val);
      move_result_type r;
      int n, len1, len2, v, i;
      longint d1, d2, t1, t2, mn1, mx1, mn2, mx2, a, b, pen;
      r.status = ST_DONE;
      r.first_delta = '0;
      r.second_delta = '0;
      r.penalty_delta = '0;
      n = active_routes();
      d1 = 0;
      d2 = 0;
      case (c)
         CMD_LOAD_DIST: dist_mem[fv][tv] = val[15:0];
         CMD_LOAD_ENTRY: route_vtx[l1][p1] = fv[5:0];
         CMD_SET_LENGTH: route_len[l1] = (val > 64) ? 64 : val;
         CMD_SET_REQ: req_flag[fv] = val[0];
         CMD_SET_TOTAL: route_tot[l1] = val;
         CMD_EVALUATE, CMD_APPLY: begin
            len1 = route_len[l1];
            len2 = route_len[l2];
            if (l1 >= n || l2 >= n || l1 == l2 || p1 >= len1 || p2 > len2 || len2 >= 64) begin
               r.status = ST_INVALID;
               return r;
            end
            v = route_vtx[l1][p1];
            if (req_flag[v]) begin
               r.status = ST_REQUIRED;
               return r;
            end
            if (p1 != 0) d1 -= dist_mem[route_vtx[l1][p1-1]][v];
            if (p1 + 1 != len1) d1 -= dist_mem[v][route_vtx[l1][p1+1]];
            if (p1 != 0 && p1 + 1 != len1)
               d1 += dist_mem[route_vtx[l1][p1-1]][route_vtx[l1][p1+1]];
            if (p2 != 0) d2 += dist_mem[route_vtx[l2][p2-1]][v];
            if (p2 != len2) d2 += dist_mem[v][route_vtx[l2][p2]];
            if (p2 != 0 && p2 != len2)
               d2 -= dist_mem[route_vtx[l2][p2-1]][route_vtx[l2][p2]];
            t1 = clamp_total(route_tot[l1] + d1);
            t2 = clamp_total(route_tot[l2] + d2);
            mn1 = route_tot[0];
            mx1 = mn1;
            mn2 = (l1 == 0) ? t1 : (l2 == 0) ? t2 : route_tot[0];
            mx2 = mn2;
            for (i = 1; i < n; i++) begin
               a = route_tot[i];
               b = (i == l1) ? t1 : (i == l2) ? t2 : a;
               if (a < mn1) mn1 = a;
               if (a > mx1) mx1 = a;
               if (b < mn2) mn2 = b;
               if (b > mx2) mx2 = b;
            end
            pen = (d1 + d2) * dist_w + ((mx2 - mn2) - (mx1 - mn1)) * spread_w
                  + (mx2 - mx1) * max_w;
            r.first_delta = d1[DELTA_W-1:0];
            r.second_delta = d2[DELTA_W-1:0];
            r.penalty_delta = pen[PENALTY_W-1:0];
            if (c == CMD_APPLY) begin
               route_tot[l1] = t1;
               route_tot[l2] = t2;
               for (i = p1; i + 1 < len1; i++) route_vtx[l1][i] = route_vtx[l1][i+1];
               route_len[l1] = len1 - 1;
               for (i = len2; i > p2; i--) route_vtx[l2][i] = route_vtx[l2][i-1];
               route_vtx[l2][p2] = v[5:0];
               route_len[l2] = len2 + 1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic issue_request(cmd_type c, int l1 = 0, int l2 = 0, int p1 = 0, int p2 = 0,
                                int fv = 0, int tv = 0, int val = 0);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= c;
      req_first_line <= LINE_W'(l1);
      req_second_line <= LINE_W'(l2);
      req_take_position <= TAKE_W'(p1);
      req_insert_position <= INSERT_W'(p2);
      req_from_vertex <= VERTEX_W'(fv);
      req_to_vertex <= VERTEX_W'(tv);
      req_load_value <= VALUE_W'(val);
      do @(posedge clock); while (busy);
      pending_results.push_back(relocate_outcome(c, l1, l2, p1, p2, fv, tv, val));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_register(reg_index_type idx, int value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= WEIGHT_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         REG_DIST_WEIGHT: dist_w = value & 16'hFFFF;
         REG_SPREAD_WEIGHT: spread_w = value & 16'hFFFF;
         REG_MAX_WEIGHT: max_w = value & 16'hFFFF;
         default: routes_raw = value & 4'hF;
      endcase
   endtask

   task automatic set_weights(int dw, int sw, int mw, int routes);
      write_register(REG_DIST_WEIGHT, dw);
      write_register(REG_SPREAD_WEIGHT, sw);
      write_register(REG_MAX_WEIGHT, mw);
      write_register(REG_ROUTES, routes);
   endtask

   task automatic test_fill_tables();
      no_gaps = 1'b1;
      foreach (vset[i]) foreach (vset[j])
         issue_request(CMD_LOAD_DIST, 0, 0, 0, 0, vset[i], vset[j], $urandom_range(0, 4194303));
      no_gaps = 1'b0;
      for (int r = 0; r < 8; r++)
         for (int p = 0; p < 64; p++)
            issue_request(CMD_LOAD_ENTRY, r, 0, p, 0, vset[$urandom_range(0, 7)]);
      for (int r = 0; r < 8; r++) begin
         issue_request(CMD_SET_LENGTH, r, 0, 0, 0, 0, 0, $urandom_range(2, 12));
         issue_request(CMD_SET_TOTAL, r, 0, 0, 0, 0, 0, $urandom_range(0, 200000));
      end
   endtask

   task automatic test_directed_cases();
      int v;
      issue_request(CMD_SET_LENGTH, 0, 0, 0, 0, 0, 0, 5);
      issue_request(CMD_SET_LENGTH, 1, 0, 0, 0, 0, 0, 3);
      issue_request(CMD_LOAD_DIST, 0, 0, 0, 0, 0, 63, 4194303);
      issue_request(CMD_LOAD_DIST, 0, 0, 0, 0, 63, 0, 0);
      issue_request(CMD_EVALUATE, 0, 1, 0, 0);
      issue_request(CMD_EVALUATE, 0, 1, 4, 3);
      issue_request(CMD_EVALUATE, 0, 1, 2, 1);
      issue_request(CMD_EVALUATE, 0, 2, 1, 1);
      issue_request(CMD_EVALUATE, 1, 1, 1, 1);
      issue_request(CMD_EVALUATE, 0, 1, 5, 0);
      issue_request(CMD_EVALUATE, 0, 1, 63, 0);
      issue_request(CMD_EVALUATE, 0, 1, 0, 4);
      issue_request(CMD_APPLY, 0, 1, 2, 1);
      v = route_vtx[0][1];
      issue_request(CMD_SET_REQ, 0, 0, 0, 0, v, 0, 1);
      issue_request(CMD_APPLY, 0, 1, 1, 0);
      issue_request(CMD_SET_REQ, 0, 0, 0, 0, v, 0, 2);
      issue_request(CMD_SET_TOTAL, 0, 0, 0, 0, 0, 0, 0);
      issue_request(CMD_SET_TOTAL, 1, 0, 0, 0, 0, 0, 4194303);
      issue_request(CMD_APPLY, 0, 1, 1, 4);
      issue_request(CMD_SET_LENGTH, 1, 0, 0, 0, 0, 0, 4194303);
      issue_request(CMD_EVALUATE, 0, 1, 0, 64);
      issue_request(CMD_EVALUATE, 1, 0, 63, 2);
      issue_request(CMD_SET_LENGTH, 1, 0, 0, 0, 0, 0, 6);
      issue_request(CMD_NOP, 7, 7, 63, 127, 63, 63, 4194303);
   endtask

   task automatic random_move(bit apply);
      int n, l1, l2, tries;
      n = active_routes();
      for (tries = 0; tries < 20; tries++) begin
         l1 = $urandom_range(0, n - 1);
         l2 = $urandom_range(0, n - 1);
         if (l1 != l2 && route_len[l1] > 0 && route_len[l2] < 64) break;
      end
      issue_request(apply ? CMD_APPLY : CMD_EVALUATE, l1, l2,
                    (route_len[l1] > 0) ? $urandom_range(0, route_len[l1] - 1) : 0,
                    $urandom_range(0, route_len[l2]), $urandom_range(0, 63),
                    $urandom_range(0, 63), $urandom_range(0, 4194303));
   endtask

   task automatic test_random_mix(int count);
      int pick, val;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (k % 60 == 0) no_gaps = $urandom_range(0, 2) == 0;
         if (pick < 35) random_move(1'b0);
         else if (pick < 60) random_move(1'b1);
         else if (pick < 70)
            issue_request($urandom_range(0, 1) ? CMD_EVALUATE : CMD_APPLY,
                          $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 63),
                          $urandom_range(0, 127), $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 4194303));
         else if (pick < 76)
            issue_request(CMD_LOAD_DIST, 0, 0, 0, 0, $urandom_range(0, 63),
                          $urandom_range(0, 63), $urandom_range(0, 4194303));
         else if (pick < 82)
            issue_request(CMD_LOAD_ENTRY, $urandom_range(0, 7), $urandom_range(0, 7),
                          $urandom_range(0, 63), 0, vset[$urandom_range(0, 7)]);
         else if (pick < 87) begin
            val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4194303)
                                               : $urandom_range(0, 20);
            issue_request(CMD_SET_LENGTH, $urandom_range(0, 7), 0, 0, 0, 0, 0, val);
         end
         else if (pick < 91)
            issue_request(CMD_SET_REQ, 0, 0, 0, 0, vset[$urandom_range(0, 7)], 0,
                          ($urandom_range(0, 3) == 0) ? 1 : 0);
         else if (pick < 98) begin
            case ($urandom_range(0, 3))
               0: val = 0;
               1: val = 4194303;
               2: val = $urandom_range(4194000, 4194303);
               default: val = $urandom_range(0, 4194303);
            endcase
            issue_request(CMD_SET_TOTAL, $urandom_range(0, 7), 0, 0, 0, 0, 0, val);
         end
         else issue_request(CMD_NOP, $urandom_range(0, 7), $urandom_range(0, 7));
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_pause_until_empty();
      random_move(1'b1);
      drain_results();
      random_move(1'b0);
   endtask

   always @(posedge clock) begin
      move_result_type e;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result status %0d", rsp_status);
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status || rsp_first_delta !== e.first_delta ||
                rsp_second_delta !== e.second_delta || rsp_penalty_delta !== e.penalty_delta) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                           e.status, e.first_delta, e.second_delta, e.penalty_delta,
                           rsp_status, rsp_first_delta, rsp_second_delta, rsp_penalty_delta);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      for (int r = 0; r < 8; r++) begin
         route_len[r] = 0;
         route_tot[r] = 0;
      end
      foreach (req_flag[i]) req_flag[i] = 1'b0;
      dist_w = 256;
      spread_w = 256;
      max_w = 256;
      routes_raw = 2;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_tables();
      test_directed_cases();
      test_random_mix(246);
      set_weights(0, 0, 0, 8);
      test_random_mix(246);
      test_pause_until_empty();
      set_weights(65535, 65535, 65535, 15);
      test_random_mix(246);
      set_weights(1, 1, 1, 0);
      test_random_mix(246);
      set_weights($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(3, 7));
      test_random_mix(246);
      drain_results();
      if (mismatches == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/rrme_pkg.sv
rtl/core/rrme_ram.sv
rtl/core/rrme_ctrl.sv
rtl/core/rrme_dp.sv
rtl/core/route_relocate_move_evaluator_top.sv
dv/tb_route_relocate_move_evaluator_top.sv
